// ----- rtl/ascii_number_double_reformat_core_assert.svh -----
// Assertion macros shared by the checker of the number reformatter.
// Needs nothing else; include it inside a module body.
`ifndef ASCII_NUMBER_DOUBLE_REFORMAT_CORE_ASSERT_SVH
`define ASCII_NUMBER_DOUBLE_REFORMAT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ANDR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ANDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/andr_pkg.sv -----
// Shared types, constants and helpers of the ASCII number reformatter.
// Depends on nothing; every module of the block imports it.
package andr_pkg;

	localparam int VALUE_BITS_DEFAULT = 32;
	localparam int OUT_DIGITS         = 10;
	localparam int NIBBLE_BITS        = 4;
	localparam int DIGIT_REG_BITS     = OUT_DIGITS * NIBBLE_BITS;
	localparam int DIGIT_IDX_BITS     = $clog2(OUT_DIGITS);
	localparam int QUEUE_DEPTH        = 4;
	localparam int QUEUE_AW           = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW           = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;

	localparam logic RADIX_DEC = 1'b0;
	localparam logic RADIX_HEX = 1'b1;

	// One classified character as it travels from front to back.
	typedef struct packed {
		logic       term;
		logic       hex;
		logic [3:0] digit;
	} andr_item_t;

	// ASCII character of one digit value, upper-case letters for ten and above.
	function automatic logic [7:0] digit_to_ascii(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CHAR_ZERO + {4'b0, nib};
		end else begin
			c = CHAR_UPPER_A + {4'b0, nib} - 8'd10;
		end
		return c;
	endfunction

endpackage

// ----- rtl/andr_queue.sv -----
// Short FIFO of classified characters between the front and the back.
// Depends on andr_pkg for the item type and the depth.
module andr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  andr_pkg::andr_item_t push_item,
	input  logic                pop,
	output andr_pkg::andr_item_t head_item,
	output logic                empty,
	output logic                full
);
	import andr_pkg::*;

	andr_item_t           mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_CW-1:0]  count_q;
	logic                 do_push;
	logic                 do_pop;

	assign empty     = (count_q == QUEUE_CW'(0));
	assign full      = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

endmodule

// ----- rtl/andr_front.sv -----
// Front end: holds the radix register, takes characters and classifies them.
// Depends on andr_pkg; pushes into andr_queue.
module andr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                radix_mode,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          char_code,
	input  logic                queue_full,
	output logic                push,
	output andr_pkg::andr_item_t push_item
);
	import andr_pkg::*;

	logic       radix_q;
	logic       hex;
	logic       is_digit;
	logic [3:0] value;

	assign cfg_ready = 1'b1;
	assign hex       = (radix_q == RADIX_HEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_DEC;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= radix_mode;
		end
	end

	always_comb begin
		is_digit = 1'b0;
		value    = 4'd0;
		if (char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
			is_digit = 1'b1;
			value    = 4'(char_code - CHAR_ZERO);
		end else if (hex && (char_code inside {[CHAR_LOWER_A:CHAR_LOWER_F]})) begin
			is_digit = 1'b1;
			value    = 4'(char_code - CHAR_LOWER_A + 8'd10);
		end else if (hex && (char_code inside {[CHAR_UPPER_A:CHAR_UPPER_F]})) begin
			is_digit = 1'b1;
			value    = 4'(char_code - CHAR_UPPER_A + 8'd10);
		end
	end

	assign in_stall        = queue_full;
	assign push            = in_valid && !queue_full;
	assign push_item.term  = !is_digit;
	assign push_item.hex   = hex;
	assign push_item.digit = value;

endmodule

// ----- rtl/andr_back.sv -----
// Back end: accumulates digits, converts the doubled value and emits digits.
// Depends on andr_pkg; pops from andr_queue and drives the result channel.
module andr_back #(
	parameter int VALUE_BITS = andr_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                queue_empty,
	input  andr_pkg::andr_item_t head_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          digit_char,
	output logic                last_digit
);
	import andr_pkg::*;

	localparam int DBL_BITS = VALUE_BITS + 1;
	localparam int CNT_W    = $clog2(DBL_BITS + 1);

	localparam logic [1:0] ST_ACC  = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_FIND = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                  state_q;
	logic [VALUE_BITS-1:0]       acc_q;
	logic [DBL_BITS-1:0]         shift_q;
	logic [CNT_W-1:0]            count_q;
	logic [DIGIT_REG_BITS-1:0]   digits_q;
	logic [DIGIT_IDX_BITS-1:0]   pos_q;
	logic                        out_valid_q;
	logic [7:0]                  digit_q;
	logic                        last_q;

	logic [VALUE_BITS-1:0]       acc_next;
	logic [VALUE_BITS-1:0]       digit_ext;
	logic [DBL_BITS-1:0]         doubled;
	logic [DBL_BITS+DIGIT_REG_BITS-1:0] doubled_ext;
	logic [DIGIT_REG_BITS-1:0]   adjusted;
	logic [DIGIT_IDX_BITS-1:0]   top_idx;
	logic [3:0]                  cur_nib;
	logic                        slot_free;

	assign out_valid  = out_valid_q;
	assign digit_char = digit_q;
	assign last_digit = last_q;
	assign slot_free  = !out_valid_q || !out_stall;
	assign pop        = (state_q == ST_ACC) && !queue_empty;

	assign digit_ext   = {{(VALUE_BITS-4){1'b0}}, head_item.digit};
	assign doubled     = {acc_q, 1'b0};
	assign doubled_ext = {{DIGIT_REG_BITS{1'b0}}, doubled};

	// Shift-and-add: times sixteen is a shift, times ten is eight plus two.
	always_comb begin
		if (head_item.hex) begin
			acc_next = (acc_q << 4) | digit_ext;
		end else begin
			acc_next = (acc_q << 3) + (acc_q << 1) + digit_ext;
		end
	end

	// Double dabble correction; carries only move upward, so the ten low digits
	// come out right without keeping the upper ones.
	always_comb begin
		for (int i = 0; i < OUT_DIGITS; i++) begin
			if (digits_q[i*NIBBLE_BITS +: NIBBLE_BITS] >= 4'd5) begin
				adjusted[i*NIBBLE_BITS +: NIBBLE_BITS] =
					digits_q[i*NIBBLE_BITS +: NIBBLE_BITS] + 4'd3;
			end else begin
				adjusted[i*NIBBLE_BITS +: NIBBLE_BITS] =
					digits_q[i*NIBBLE_BITS +: NIBBLE_BITS];
			end
		end
	end

	always_comb begin
		top_idx = '0;
		for (int i = 0; i < OUT_DIGITS; i++) begin
			if (digits_q[i*NIBBLE_BITS +: NIBBLE_BITS] != 4'd0) begin
				top_idx = DIGIT_IDX_BITS'(i);
			end
		end
	end

	assign cur_nib = digits_q[pos_q*NIBBLE_BITS +: NIBBLE_BITS];

	always_ff @(posedge clk) begin
		if (state_q == ST_ACC && !queue_empty && head_item.term) begin
			shift_q <= doubled;
		end else if (state_q == ST_CONV) begin
			shift_q <= shift_q << 1;
		end
		if (state_q == ST_ACC && !queue_empty && head_item.term) begin
			if (head_item.hex) begin
				digits_q <= doubled_ext[DIGIT_REG_BITS-1:0];
			end else begin
				digits_q <= '0;
			end
		end else if (state_q == ST_CONV) begin
			digits_q <= {adjusted[DIGIT_REG_BITS-2:0], shift_q[DBL_BITS-1]};
		end
		if (state_q == ST_EMIT && slot_free) begin
			digit_q <= digit_to_ascii(cur_nib);
			last_q  <= (pos_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			acc_q       <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= (state_q == ST_EMIT);
			end
			case (state_q)
				ST_ACC: begin
					if (!queue_empty) begin
						if (head_item.term) begin
							acc_q   <= '0;
							count_q <= CNT_W'(DBL_BITS);
							state_q <= head_item.hex ? ST_FIND : ST_CONV;
						end else begin
							acc_q <= acc_next;
						end
					end
				end
				ST_CONV: begin
					count_q <= count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					pos_q   <= top_idx;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (pos_q == '0) begin
							state_q <= ST_ACC;
						end else begin
							pos_q <= pos_q - DIGIT_IDX_BITS'(1);
						end
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

endmodule

// ----- rtl/ascii_number_double_reformat_core.sv -----
// ASCII number reformatter. Characters arrive one per request on the input
// channel. While they are digits of the radix held in the radix_mode register
// (0 decimal, 1 hexadecimal with either letter case) they build an unsigned
// VALUE_BITS-bit number that wraps on overflow; the first other character
// ends the number and is dropped. The number is doubled and sent out as ASCII
// digits, most significant first, upper-case letters, no leading zeros, a zero
// value giving a single '0', and last_digit set on the final digit; only the
// ten least significant digits are sent. The front classifies each character
// in the cycle it is taken and writes it into a four-entry queue, so input is
// taken every cycle until the queue fills. The back takes one queue entry per
// cycle while it accumulates and the queue holds one, and takes none while it
// converts or sends a number. A terminator in decimal is taken from the queue
// and followed by bit-serial binary-to-decimal conversion of the doubled
// value, the search for the leading digit and the sending of the digits; in
// hexadecimal the conversion falls away. A stalled digit holds the back until
// it is taken, except the final digit of a number: the result register keeps
// it while the back goes on with the next queue entry. Write radix_mode only
// while no number is being converted or sent.
module ascii_number_double_reformat_core #(
	parameter int VALUE_BITS = andr_pkg::VALUE_BITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       radix_mode,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] digit_char,
	output logic       last_digit
);
	import andr_pkg::*;

	// Classified characters pass from front to back through this queue.
	andr_item_t push_item;
	andr_item_t head_item;
	logic       push;
	logic       pop;
	logic       queue_empty;
	logic       queue_full;

	// The front owns the radix register and the input handshake.
	andr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.radix_mode (radix_mode),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	andr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.empty     (queue_empty),
		.full      (queue_full)
	);

	// The back holds the accumulator, the converter and the result register.
	andr_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head_item   (head_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digit_char  (digit_char),
		.last_digit  (last_digit)
	);

endmodule

// ----- rtl/andr_checker.sv -----
// Port-level checker of the number reformatter, bound to the top level.
// Depends on andr_pkg and the assertion macro header.
module andr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] digit_char,
	input logic       last_digit
);
	import andr_pkg::*;
	`include "ascii_number_double_reformat_core_assert.svh"

	// Set while the next result request opens a new number.
	logic first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (out_valid && !out_stall) begin
			first_q <= last_digit;
		end
	end

	`ANDR_ASSERT_NEXT(a_valid_held, clk, arst_n, out_valid && out_stall, out_valid)
	`ANDR_ASSERT_NEXT(a_payload_held, clk, arst_n, out_valid && out_stall, $stable(digit_char) && $stable(last_digit))
	`ANDR_ASSERT_SAME(a_digit_legal, clk, arst_n, out_valid, (digit_char >= CHAR_ZERO && digit_char <= CHAR_NINE) || (digit_char >= CHAR_UPPER_A && digit_char <= CHAR_UPPER_F))
	`ANDR_ASSERT_SAME(a_no_lead_zero, clk, arst_n, out_valid && first_q && digit_char == CHAR_ZERO, last_digit)

endmodule

bind ascii_number_double_reformat_core andr_checker u_andr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.digit_char (digit_char),
	.last_digit (last_digit)
);
